FILE: rtl/point_in_polygon_test_macros.svh
// Assertion macros shared by the point-in-polygon block.
`ifndef POINT_IN_POLYGON_TEST_MACROS_SVH
`define POINT_IN_POLYGON_TEST_MACROS_SVH

// Same-cycle implication, checked on aclk, off while in reset.
`define PIP_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on aclk, off while in reset.
`define PIP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/pip_pkg.sv
// Shared constants, types and helpers of the point-in-polygon block.
`timescale 1ns / 1ps

package pip_pkg;

    localparam int MAX_VERTICES = 64;
    localparam int COORD_BITS   = 24;
    localparam int ADDR_BITS    = $clog2(MAX_VERTICES);
    localparam int NUM_BITS     = $clog2(MAX_VERTICES + 1);
    localparam int CFG_BITS     = 7;
    localparam int DIFF_BITS    = COORD_BITS + 1;
    localparam int PROD_BITS    = 2 * DIFF_BITS;
    localparam int VERT_BITS    = 2 * COORD_BITS;
    localparam int IDX_IN_BITS  = 6;

    // Input tdata layout: vertex_index, coord_x, coord_y, padded to whole bytes
    localparam int X_LSB        = IDX_IN_BITS;
    localparam int Y_LSB        = IDX_IN_BITS + COORD_BITS;
    localparam int S_DATA_BITS  = ((Y_LSB + COORD_BITS + 7) / 8) * 8;

    typedef logic [S_DATA_BITS-1:0] s_data_t;

    // Item kinds carried on tuser
    localparam logic KIND_LOAD  = 1'b0;
    localparam logic KIND_QUERY = 1'b1;

    // Register word index
    localparam logic REG_VERTEX_COUNT = 1'b0;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PREV,
        S_MUL1,
        S_MUL2,
        S_CMP,
        S_DONE
    } state_t;

    // Controls from the sequencer to the datapath and output stage
    typedef struct packed {
        logic start;
        logic load_prev;
        logic cap_cur;
        logic first;
        logic mul_en;
        logic mul_sel;
        logic hold_en;
        logic cmp_en;
        logic out_load;
    } ctrl_t;

    function automatic logic signed [DIFF_BITS-1:0] sext_d(logic signed [COORD_BITS-1:0] v);
        return {v[COORD_BITS-1], v};
    endfunction

endpackage

FILE: rtl/pip_vstore.sv
// Vertex store: one write port, one registered read port.
`timescale 1ns / 1ps

module pip_vstore (
    input  logic                                aclk,
    input  logic                                wr_en,
    input  logic [pip_pkg::ADDR_BITS-1:0]       wr_addr,
    input  logic [pip_pkg::VERT_BITS-1:0]       wr_data,
    input  logic [pip_pkg::ADDR_BITS-1:0]       rd_addr,
    output logic [pip_pkg::VERT_BITS-1:0]       rd_data
);

    logic [pip_pkg::VERT_BITS-1:0] mem [pip_pkg::MAX_VERTICES];
    logic [pip_pkg::VERT_BITS-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: rtl/pip_ctrl.sv
// Sequencer: walks the edges of the stored polygon for one query.
`timescale 1ns / 1ps

module pip_ctrl (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              query_acc,
    input  logic [pip_pkg::CFG_BITS-1:0]      vertex_count,
    input  logic                              out_free,
    output pip_pkg::ctrl_t                    ctrl,
    output logic [pip_pkg::ADDR_BITS-1:0]     rd_addr,
    output logic                              idle
);

    pip_pkg::state_t               state_reg, state_next;
    logic [pip_pkg::ADDR_BITS-1:0] idx_reg, idx_next;
    logic [pip_pkg::NUM_BITS-1:0]  num_reg, num_next;
    logic [pip_pkg::NUM_BITS-1:0]  num_cfg;
    logic                          last_edge;

    // Clamp the vertex count to the store depth
    always_comb begin
        if (int'(vertex_count) > pip_pkg::MAX_VERTICES) begin
            num_cfg = pip_pkg::NUM_BITS'(pip_pkg::MAX_VERTICES);
        end else begin
            num_cfg = pip_pkg::NUM_BITS'(vertex_count);
        end
    end

    assign last_edge = (pip_pkg::NUM_BITS'(idx_reg) == num_reg - 1'b1);

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            pip_pkg::S_IDLE: begin
                if (query_acc) begin
                    state_next = (num_cfg == '0) ? pip_pkg::S_DONE : pip_pkg::S_PREV;
                end
            end
            pip_pkg::S_PREV: state_next = pip_pkg::S_MUL1;
            pip_pkg::S_MUL1: state_next = pip_pkg::S_MUL2;
            pip_pkg::S_MUL2: state_next = pip_pkg::S_CMP;
            pip_pkg::S_CMP: begin
                state_next = last_edge ? pip_pkg::S_DONE : pip_pkg::S_MUL1;
            end
            pip_pkg::S_DONE: begin
                if (out_free) begin
                    state_next = pip_pkg::S_IDLE;
                end
            end
            default: state_next = pip_pkg::S_IDLE;
        endcase
    end

    // Outputs, read address and counters
    always_comb begin
        ctrl     = '0;
        rd_addr  = idx_reg;
        idx_next = idx_reg;
        num_next = num_reg;
        idle     = 1'b0;
        unique case (state_reg)
            pip_pkg::S_IDLE: begin
                idle = 1'b1;
                // fetch the closing vertex first so edge 0 has its predecessor
                rd_addr = pip_pkg::ADDR_BITS'(num_cfg - 1'b1);
                if (query_acc) begin
                    ctrl.start = 1'b1;
                    num_next   = num_cfg;
                end
            end
            pip_pkg::S_PREV: begin
                ctrl.load_prev = 1'b1;
                rd_addr        = '0;
                idx_next       = '0;
            end
            pip_pkg::S_MUL1: begin
                ctrl.cap_cur = 1'b1;
                ctrl.first   = (idx_reg == '0);
                ctrl.mul_en  = 1'b1;
                ctrl.mul_sel = 1'b0;
            end
            pip_pkg::S_MUL2: begin
                ctrl.mul_en  = 1'b1;
                ctrl.mul_sel = 1'b1;
                ctrl.hold_en = 1'b1;
            end
            pip_pkg::S_CMP: begin
                ctrl.cmp_en = 1'b1;
                rd_addr     = idx_reg + 1'b1;
                idx_next    = idx_reg + 1'b1;
            end
            pip_pkg::S_DONE: begin
                ctrl.out_load = out_free;
            end
            default: begin
                idle = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= pip_pkg::S_IDLE;
            idx_reg   <= '0;
            num_reg   <= '0;
        end else begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            num_reg   <= num_next;
        end
    end

endmodule

FILE: rtl/pip_dpath.sv
// Datapath: shared multiplier, crossing parity and bounding box.
`timescale 1ns / 1ps

module pip_dpath (
    input  logic                                     aclk,
    input  logic                                     aresetn,
    input  pip_pkg::ctrl_t                           ctrl,
    input  logic signed [pip_pkg::COORD_BITS-1:0]    point_x,
    input  logic signed [pip_pkg::COORD_BITS-1:0]    point_y,
    input  logic [pip_pkg::VERT_BITS-1:0]            rd_data,
    output logic                                     parity,
    output logic                                     in_box
);

    localparam int C = pip_pkg::COORD_BITS;

    logic signed [C-1:0] px_reg, py_reg;
    logic signed [C-1:0] prev_x_reg, prev_y_reg, cur_x_reg, cur_y_reg;
    logic signed [C-1:0] min_x_reg, max_x_reg, min_y_reg, max_y_reg;
    logic signed [C-1:0] rd_x, rd_y;
    logic signed [pip_pkg::DIFF_BITS-1:0] op_a, op_b;
    logic signed [pip_pkg::PROD_BITS-1:0] prod_next, prod_reg, hold_reg;
    logic parity_reg, box_vld_reg;
    logic straddle, dy_pos, left;

    assign rd_x = signed'(rd_data[C-1:0]);
    assign rd_y = signed'(rd_data[2*C-1:C]);

    // Operand select: (px - x1) * (y2 - y1), then (x2 - x1) * (py - y1)
    always_comb begin
        if (!ctrl.mul_sel) begin
            op_a = pip_pkg::sext_d(px_reg) - pip_pkg::sext_d(rd_x);
            op_b = pip_pkg::sext_d(prev_y_reg) - pip_pkg::sext_d(rd_y);
        end else begin
            op_a = pip_pkg::sext_d(prev_x_reg) - pip_pkg::sext_d(cur_x_reg);
            op_b = pip_pkg::sext_d(py_reg) - pip_pkg::sext_d(cur_y_reg);
        end
    end

    assign prod_next = pip_pkg::PROD_BITS'(op_a) * pip_pkg::PROD_BITS'(op_b);

    // Edge test on the registered products
    assign straddle = (cur_y_reg > py_reg) != (prev_y_reg > py_reg);
    assign dy_pos   = prev_y_reg > cur_y_reg;
    assign left     = dy_pos ? (hold_reg < prod_reg) : (prod_reg < hold_reg);

    always_ff @(posedge aclk) begin
        if (ctrl.start) begin
            px_reg <= point_x;
            py_reg <= point_y;
        end
        if (ctrl.load_prev) begin
            prev_x_reg <= rd_x;
            prev_y_reg <= rd_y;
        end
        if (ctrl.cap_cur) begin
            cur_x_reg <= rd_x;
            cur_y_reg <= rd_y;
        end
        if (ctrl.cmp_en) begin
            prev_x_reg <= cur_x_reg;
            prev_y_reg <= cur_y_reg;
        end
        if (ctrl.mul_en) begin
            prod_reg <= prod_next;
        end
        if (ctrl.hold_en) begin
            hold_reg <= prod_reg;
        end
        // bounding box over the vertices as they are fetched
        if (ctrl.cap_cur) begin
            if (ctrl.first || rd_x < min_x_reg) min_x_reg <= rd_x;
            if (ctrl.first || rd_x > max_x_reg) max_x_reg <= rd_x;
            if (ctrl.first || rd_y < min_y_reg) min_y_reg <= rd_y;
            if (ctrl.first || rd_y > max_y_reg) max_y_reg <= rd_y;
        end
    end

    // Parity and box-valid flags
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            parity_reg  <= 1'b0;
            box_vld_reg <= 1'b0;
        end else if (ctrl.start) begin
            parity_reg  <= 1'b0;
            box_vld_reg <= 1'b0;
        end else begin
            if (ctrl.cmp_en && straddle && left) begin
                parity_reg <= !parity_reg;
            end
            if (ctrl.cap_cur) begin
                box_vld_reg <= 1'b1;
            end
        end
    end

    assign parity = parity_reg;
    assign in_box = box_vld_reg && (px_reg > min_x_reg) && (px_reg < max_x_reg)
                    && (py_reg > min_y_reg) && (py_reg < max_y_reg);

endmodule

FILE: rtl/point_in_polygon_test.sv
// Top level of the even-odd point-in-polygon test with APB register port.
//
//  channel  | dir | contents
//  ---------+-----+---------------------------------------------------------
//  s_axis   | in  | tuser: kind; tdata: vertex_index, coord_x, coord_y
//  m_axis   | out | tdata: inside_res, crossing_parity, in_bounding_box
//  apb      | in  | vertex_count at byte address 0
//
// A load is written straight into the vertex store.
// A query holds the block busy until the next item can be accepted: one shared
// 25x25 multiplier forms two products per edge, and each edge goes through a
// multiply, a multiply and a compare state (S_MUL1, S_MUL2, S_CMP).
// A query with no vertices goes straight from idle to the done state.
// Reset (aresetn low, synchronous) clears the sequencer, flags and register;
// the vertex store is not cleared. A stalled result holds in the output
// register; the block idles and takes items, but the next result waits in S_DONE.
`timescale 1ns / 1ps

`include "point_in_polygon_test_macros.svh"

module point_in_polygon_test (
    input  logic        aclk,
    input  logic        aresetn,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  pip_pkg::s_data_t s_tdata,  // [5:0] vertex_index, [29:6] coord_x, [53:30] coord_y
    input  logic [0:0]  s_tuser,   // [0] kind
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [0] inside_res, [1] crossing_parity, [2] in_bounding_box
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int C = pip_pkg::COORD_BITS;

    logic [pip_pkg::IDX_IN_BITS-1:0]   in_index;
    logic signed [C-1:0]               in_x, in_y;
    logic                              in_kind;
    logic                              s_acc, query_acc, load_acc;
    logic                              idle, out_free;
    logic [pip_pkg::CFG_BITS-1:0]      vcount_reg;
    logic                              cfg_wr;
    pip_pkg::ctrl_t                    ctrl;
    logic [pip_pkg::ADDR_BITS-1:0]     rd_addr;
    logic [pip_pkg::VERT_BITS-1:0]     rd_data;
    logic                              parity, in_box;
    logic                              m_valid_reg;
    logic [2:0]                        m_data_reg;

    // Input unpacking
    assign in_index = s_tdata[pip_pkg::IDX_IN_BITS-1:0];
    assign in_x     = signed'(s_tdata[pip_pkg::X_LSB +: C]);
    assign in_y     = signed'(s_tdata[pip_pkg::Y_LSB +: C]);
    assign in_kind  = s_tuser[0];

    assign s_tready  = idle;
    assign s_acc     = s_tvalid && s_tready;
    assign query_acc = s_acc && (in_kind == pip_pkg::KIND_QUERY);
    assign load_acc  = s_acc && (in_kind == pip_pkg::KIND_LOAD)
                       && (int'(in_index) < pip_pkg::MAX_VERTICES);

    // APB register
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready
                    && (paddr[2] == pip_pkg::REG_VERTEX_COUNT);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vcount_reg <= '0;
        end else if (cfg_wr) begin
            vcount_reg <= pwdata[pip_pkg::CFG_BITS-1:0];
        end
    end

    always_comb begin
        prdata = '0;
        if (paddr[2] == pip_pkg::REG_VERTEX_COUNT) begin
            prdata = {{(32 - pip_pkg::CFG_BITS){1'b0}}, vcount_reg};
        end
    end

    pip_vstore u_vstore (
        .aclk    (aclk),
        .wr_en   (load_acc),
        .wr_addr (pip_pkg::ADDR_BITS'(in_index)),
        .wr_data ({in_y, in_x}),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    pip_ctrl u_ctrl (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .query_acc    (query_acc),
        .vertex_count (vcount_reg),
        .out_free     (out_free),
        .ctrl         (ctrl),
        .rd_addr      (rd_addr),
        .idle         (idle)
    );

    pip_dpath u_dpath (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (ctrl),
        .point_x (in_x),
        .point_y (in_y),
        .rd_data (rd_data),
        .parity  (parity),
        .in_box  (in_box)
    );

    // Output register
    assign out_free = !m_valid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (ctrl.out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.out_load) begin
            m_data_reg <= {in_box, parity, parity && in_box};
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {5'b0, m_data_reg};

    // Checks
    `PIP_ASSERT_NEXT(a_query_busy, query_acc, !s_tready, "query did not make the block busy")
    `PIP_ASSERT_NEXT(a_load_one_cycle, load_acc, s_tready, "load did not finish in one cycle")
    `PIP_ASSERT_NOW(a_no_overwrite, ctrl.out_load, !m_tvalid || m_tready, "result overwritten")
    `PIP_ASSERT_NOW(a_inside_and, m_tvalid, m_tdata[0] == &m_tdata[2:1], "bad inside_res")

endmodule
